FILE: hdl/sgp_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sgp_pkg
// Shared sizes, types and status codes of the row-major grid point sorter.
// ----------------------------------------------------------------------------
package sgp_pkg;

    localparam int MAX_POINTS     = 48;
    localparam int POINTS_PER_ROW = 3;

    localparam int COORD_W = 16;
    localparam int CNT_W   = $clog2(MAX_POINTS + 1);
    localparam int ADDR_W  = $clog2(MAX_POINTS);
    localparam int ROW_W   = (POINTS_PER_ROW > 1) ? $clog2(POINTS_PER_ROW) : 1;
    localparam int KIDX_W  = (CNT_W > ROW_W) ? CNT_W : ROW_W;
    localparam int KEY_W   = COORD_W + KIDX_W;

    typedef logic [1:0] t_status;

    localparam t_status ST_OK           = 2'd0;
    localparam t_status ST_NOT_MULTIPLE = 2'd1;
    localparam t_status ST_OVERFLOW     = 2'd2;

endpackage

FILE: hdl/sort_grid_points_row_major.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sort_grid_points_row_major
// Collects a set of points, then emits them in row-major grid order.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (i_valid / o_stall): one point per transfer, one transfer
//   per cycle while loading. i_last_point closes the set and starts sorting;
//   o_stall stays high until the whole set has been handed to the output
//   register.
//   Output channel (o_valid / i_stall): one result per transfer. A good set
//   gives one result per point, last one marked; a set whose count is not a
//   multiple of the row size, or that overflowed the store, gives a single
//   marked result with an error status and is dropped.
//   Sequence: after the last point, a check state. Each point then takes one
//   scan of the point RAM by a shared key comparator, plus a scan of the
//   row buffer and one emit step. Receiver stall holds the output register
//   and pauses the sequencer in its emit and error states.
//   Reset clears the point count, the overflow flag and both valids; the
//   point RAM is not cleared.
// ----------------------------------------------------------------------------
module sort_grid_points_row_major
    import sgp_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_stall,
    input  logic [COORD_W-1:0] i_x_pos,
    input  logic [COORD_W-1:0] i_y_pos,
    input  logic               i_last_point,
    output logic               o_valid,
    input  logic               i_stall,
    output logic [COORD_W-1:0] o_x_out,
    output logic [COORD_W-1:0] o_y_out,
    output logic               o_last_out,
    output t_status            o_status
);

    localparam logic [2:0] S_LOAD  = 3'd0;
    localparam logic [2:0] S_CHECK = 3'd1;
    localparam logic [2:0] S_SCAN  = 3'd2;
    localparam logic [2:0] S_ROW   = 3'd3;
    localparam logic [2:0] S_EMIT  = 3'd4;
    localparam logic [2:0] S_ERR   = 3'd5;

    localparam logic [ROW_W-1:0] ROW_LAST = ROW_W'(POINTS_PER_ROW - 1);
    localparam logic [CNT_W-1:0] CNT_MAX  = CNT_W'(MAX_POINTS);

    logic [2:0]         r_state;
    logic [CNT_W-1:0]   r_count;
    logic               r_ovf;
    logic [ROW_W-1:0]   r_mod;

    // y scan over the point RAM
    logic [CNT_W-1:0]   r_addr;
    logic               r_issue;
    logic               r_rd_v;
    logic [CNT_W-1:0]   r_rd_idx;
    logic               r_have_prev;
    logic [KEY_W-1:0]   r_prev_key;

    // best candidate of the current scan
    logic               r_best_v;
    logic [KEY_W-1:0]   r_best_key;
    logic [COORD_W-1:0] r_best_x;
    logic [COORD_W-1:0] r_best_y;

    // row buffer and x scan
    logic [COORD_W-1:0] r_row_x [POINTS_PER_ROW];
    logic [COORD_W-1:0] r_row_y [POINTS_PER_ROW];
    logic [ROW_W-1:0]   r_fill;
    logic [ROW_W-1:0]   r_rp;
    logic               r_rhave;
    logic [KEY_W-1:0]   r_rprev_key;
    logic [ROW_W-1:0]   r_rsel;
    logic [CNT_W-1:0]   r_emit;

    logic               r_out_v;
    logic [COORD_W-1:0] r_out_x;
    logic [COORD_W-1:0] r_out_y;
    logic               r_out_last;
    t_status            r_out_status;

    logic                 in_xfer;
    logic                 out_free;
    logic                 ram_we;
    logic [2*COORD_W-1:0] ram_rdata;
    logic [CNT_W-1:0]     last_idx;
    logic                 row_mode;
    logic [KEY_W-1:0]     cand_key;
    logic [COORD_W-1:0]   cand_x;
    logic [COORD_W-1:0]   cand_y;
    logic [KEY_W-1:0]     prev_key;
    logic                 have_prev;
    logic                 cand_step;
    logic                 cand_ok;
    logic                 cand_better;
    logic                 n_best_v;
    logic [KEY_W-1:0]     n_best_key;
    logic [COORD_W-1:0]   n_best_x;
    logic [COORD_W-1:0]   n_best_y;
    logic                 scan_done;

    assign in_xfer  = i_valid && !o_stall;
    assign out_free = !r_out_v || !i_stall;
    assign o_stall  = (r_state != S_LOAD);
    assign ram_we   = in_xfer && (r_count < CNT_MAX);
    assign last_idx = r_count - CNT_W'(1);

    sgp_ram #(
        .WIDTH (2 * COORD_W),
        .DEPTH (MAX_POINTS)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (r_count[ADDR_W-1:0]),
        .i_wdata ({i_x_pos, i_y_pos}),
        .i_re    (r_issue),
        .i_raddr (r_addr[ADDR_W-1:0]),
        .o_rdata (ram_rdata)
    );

    // Shared key comparator: (y, arrival index) in the RAM scan,
    // (x, row position) in the row scan.
    always_comb begin
        row_mode = (r_state == S_ROW);
        if (row_mode) begin
            cand_x    = r_row_x[r_rp];
            cand_y    = r_row_y[r_rp];
            cand_key  = {r_row_x[r_rp], KIDX_W'(r_rp)};
            prev_key  = r_rprev_key;
            have_prev = r_rhave;
            cand_step = 1'b1;
        end else begin
            cand_x    = ram_rdata[2*COORD_W-1:COORD_W];
            cand_y    = ram_rdata[COORD_W-1:0];
            cand_key  = {ram_rdata[COORD_W-1:0], KIDX_W'(r_rd_idx)};
            prev_key  = r_prev_key;
            have_prev = r_have_prev;
            cand_step = (r_state == S_SCAN) && r_rd_v;
        end
        cand_ok     = !have_prev || (cand_key > prev_key);
        cand_better = cand_step && cand_ok && (!r_best_v || (cand_key < r_best_key));
        n_best_v    = r_best_v || cand_better;
        n_best_key  = cand_better ? cand_key : r_best_key;
        n_best_x    = cand_better ? cand_x : r_best_x;
        n_best_y    = cand_better ? cand_y : r_best_y;
        scan_done   = (r_state == S_SCAN) && r_rd_v && (r_rd_idx == last_idx);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_LOAD;
            r_count     <= '0;
            r_ovf       <= 1'b0;
            r_mod       <= '0;
            r_issue     <= 1'b0;
            r_rd_v      <= 1'b0;
            r_have_prev <= 1'b0;
            r_best_v    <= 1'b0;
            r_rhave     <= 1'b0;
            r_out_v     <= 1'b0;
        end else begin
            if (r_out_v && !i_stall) begin
                r_out_v <= 1'b0;
            end
            r_best_v <= n_best_v;
            unique case (r_state)
                S_LOAD: begin
                    if (in_xfer) begin
                        if (r_count < CNT_MAX) begin
                            r_count <= r_count + CNT_W'(1);
                            r_mod   <= (r_mod == ROW_LAST) ? '0 : r_mod + ROW_W'(1);
                        end else begin
                            r_ovf <= 1'b1;
                        end
                        if (i_last_point) begin
                            r_state <= S_CHECK;
                        end
                    end
                end
                S_CHECK: begin
                    if (r_ovf || (r_mod != '0)) begin
                        r_state <= S_ERR;
                    end else begin
                        r_state     <= S_SCAN;
                        r_addr      <= '0;
                        r_issue     <= 1'b1;
                        r_have_prev <= 1'b0;
                        r_best_v    <= 1'b0;
                        r_fill      <= '0;
                        r_rsel      <= '0;
                        r_emit      <= '0;
                    end
                end
                S_SCAN: begin
                    if (r_issue) begin
                        r_addr <= r_addr + CNT_W'(1);
                        if (r_addr == last_idx) begin
                            r_issue <= 1'b0;
                        end
                    end
                    r_rd_v   <= r_issue;
                    r_rd_idx <= r_addr;
                    if (scan_done) begin
                        // park the selected point in the row buffer
                        r_row_x[r_fill] <= n_best_x;
                        r_row_y[r_fill] <= n_best_y;
                        r_prev_key      <= n_best_key;
                        r_have_prev     <= 1'b1;
                        r_best_v        <= 1'b0;
                        if (r_fill == ROW_LAST) begin
                            r_fill  <= '0;
                            r_rp    <= '0;
                            r_rhave <= 1'b0;
                            r_state <= S_ROW;
                        end else begin
                            r_fill  <= r_fill + ROW_W'(1);
                            r_addr  <= '0;
                            r_issue <= 1'b1;
                        end
                    end
                end
                S_ROW: begin
                    r_best_key <= n_best_key;
                    r_best_x   <= n_best_x;
                    r_best_y   <= n_best_y;
                    if (r_rp == ROW_LAST) begin
                        r_rp    <= '0;
                        r_state <= S_EMIT;
                    end else begin
                        r_rp <= r_rp + ROW_W'(1);
                    end
                end
                S_EMIT: begin
                    if (out_free) begin
                        r_out_v      <= 1'b1;
                        r_out_x      <= r_best_x;
                        r_out_y      <= r_best_y;
                        r_out_last   <= (r_emit == last_idx);
                        r_out_status <= ST_OK;
                        r_emit       <= r_emit + CNT_W'(1);
                        r_best_v     <= 1'b0;
                        r_rprev_key  <= r_best_key;
                        r_rhave      <= 1'b1;
                        if (r_rsel == ROW_LAST) begin
                            r_rsel <= '0;
                            if (r_emit == last_idx) begin
                                r_count <= '0;
                                r_ovf   <= 1'b0;
                                r_mod   <= '0;
                                r_state <= S_LOAD;
                            end else begin
                                r_addr  <= '0;
                                r_issue <= 1'b1;
                                r_state <= S_SCAN;
                            end
                        end else begin
                            r_rsel  <= r_rsel + ROW_W'(1);
                            r_state <= S_ROW;
                        end
                    end
                end
                S_ERR: begin
                    if (out_free) begin
                        r_out_v      <= 1'b1;
                        r_out_x      <= '0;
                        r_out_y      <= '0;
                        r_out_last   <= 1'b1;
                        r_out_status <= r_ovf ? ST_OVERFLOW : ST_NOT_MULTIPLE;
                        r_count      <= '0;
                        r_ovf        <= 1'b0;
                        r_mod        <= '0;
                        r_state      <= S_LOAD;
                    end
                end
                default: begin
                    r_state <= S_LOAD;
                end
            endcase
            if (r_state != S_SCAN && r_state != S_ROW) begin
                // best only tracks during scans; keep payload registers in step
                if (r_state != S_EMIT) begin
                    r_best_key <= n_best_key;
                end
            end
            if (r_state == S_SCAN) begin
                r_best_key <= n_best_key;
                r_best_x   <= n_best_x;
                r_best_y   <= n_best_y;
            end
        end
    end

    assign o_valid    = r_out_v;
    assign o_x_out    = r_out_x;
    assign o_y_out    = r_out_y;
    assign o_last_out = r_out_last;
    assign o_status   = r_out_status;

endmodule

FILE: hdl/sgp_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sgp_ram
// Generic single-write, single-read RAM with a registered read port.
// ----------------------------------------------------------------------------
module sgp_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 48
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

FILE: hdl/sgp_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sgp_checker
// Port-level checks of the grid point sorter, bound to the top level.
// ----------------------------------------------------------------------------
module sgp_checker
    import sgp_pkg::*;
(
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               i_valid,
    input logic               o_stall,
    input logic [COORD_W-1:0] i_x_pos,
    input logic [COORD_W-1:0] i_y_pos,
    input logic               i_last_point,
    input logic               o_valid,
    input logic               i_stall,
    input logic [COORD_W-1:0] o_x_out,
    input logic [COORD_W-1:0] o_y_out,
    input logic               o_last_out,
    input t_status            o_status
);

    // a stalled result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_x_out) && $stable(o_y_out)
            && $stable(o_last_out) && $stable(o_status))
        else $error("stalled result changed");

    // error results close the run and carry no point
    a_err_form: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_status != ST_OK |-> o_last_out && o_x_out == '0 && o_y_out == '0)
        else $error("malformed error result");

    a_status_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> o_status == ST_OK || o_status == ST_NOT_MULTIPLE
            || o_status == ST_OVERFLOW)
        else $error("unknown status code");

    // a closing point starts the sort, so the next cycle takes no input
    a_last_blocks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && !o_stall && i_last_point |=> o_stall)
        else $error("input taken right after last point");

    a_reset_idle: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid && !o_stall)
        else $error("not idle after reset");

endmodule

bind sort_grid_points_row_major sgp_checker u_sgp_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .i_valid      (i_valid),
    .o_stall      (o_stall),
    .i_x_pos      (i_x_pos),
    .i_y_pos      (i_y_pos),
    .i_last_point (i_last_point),
    .o_valid      (o_valid),
    .i_stall      (i_stall),
    .o_x_out      (o_x_out),
    .o_y_out      (o_y_out),
    .o_last_out   (o_last_out),
    .o_status     (o_status)
);
